[rtl/sha1_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-1 package
// Shared types and constants for the SHA-1 digest unit.
// ----------------------------------------------------------------------------
package sha1_pkg;
	localparam logic [31:0] H0_INIT = 32'h67452301;
	localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
	localparam logic [31:0] H2_INIT = 32'h98BADCFE;
	localparam logic [31:0] H3_INIT = 32'h10325476;
	localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;
	localparam logic [31:0] K0 = 32'h5A827999;
	localparam logic [31:0] K1 = 32'h6ED9EBA1;
	localparam logic [31:0] K2 = 32'h8F1BBCDC;
	localparam logic [31:0] K3 = 32'hCA62C1D6;
	localparam logic [7:0]  PAD_BYTE = 8'h80;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_present;
		logic       message_end;
	} in_word_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic        last_word;
	} out_word_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ABSORB,
		ST_PAD,
		ST_LEN,
		ST_ROUND,
		ST_EMIT
	} core_state_t;
endpackage

[rtl/sha1_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-1 stream channel
// Valid/ready channel carrying one payload word.
// ----------------------------------------------------------------------------
interface sha1_if #(parameter int W = 8);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[rtl/sha1_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-1 input queue
// Two-entry queue between the front end and the compression core.
// ----------------------------------------------------------------------------
module sha1_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  sha1_pkg::in_word_t push_data,
	output logic             full,
	input  logic             pop,
	output sha1_pkg::in_word_t pop_data,
	output logic             empty
);
	import sha1_pkg::*;
	in_word_t   mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign pop_data = mem_q[rp_q];

	always_ff @(posedge clk) begin
		if (push && !full) mem_q[wp_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push && !full) wp_q <= ~wp_q;
			if (pop && !empty) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push && !full) - 2'(pop && !empty);
		end
	end
endmodule

[rtl/sha1_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-1 compression core
// Absorbs bytes, pads, runs 80 rounds per block, emits the digest.
// ----------------------------------------------------------------------------
module sha1_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  sha1_pkg::in_word_t in_data,
	output logic               in_pop,
	output logic               out_valid,
	output sha1_pkg::out_word_t out_data,
	input  logic               out_ready
);
	import sha1_pkg::*;
	core_state_t state_q, state_d;
	logic [31:0] h_q [5];
	logic [31:0] r_q [5];
	logic [31:0] w_q [16];
	logic [31:0] acc_q;
	logic [5:0]  pos_q;
	logic [63:0] bits_q;
	logic [63:0] len_q;
	logic [6:0]  rnd_q;
	logic [2:0]  cnt_q;
	logic        fin_q;
	logic        endp_q;

	logic        put;
	logic [7:0]  put_byte;
	logic [6:0]  t;
	logic [31:0] wt2, f2, k2, tmp2;

	always_comb begin
		put = 1'b0;
		put_byte = 8'h00;
		case (state_q)
			ST_ABSORB: begin
				put = in_data.byte_present;
				put_byte = in_data.data_byte;
			end
			ST_PAD: begin
				put = 1'b1;
				put_byte = fin_q ? 8'h00 : PAD_BYTE;
			end
			ST_LEN: begin
				put = 1'b1;
				put_byte = len_q[63:56];
			end
			default: ;
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (in_valid) state_d = ST_ABSORB;
			ST_ABSORB: begin
				if (in_data.byte_present && pos_q == 6'd63) state_d = ST_ROUND;
				else if (in_data.message_end) state_d = ST_PAD;
				else state_d = ST_IDLE;
			end
			ST_PAD: begin
				if (pos_q == 6'd63) state_d = ST_ROUND;
				else if (pos_q == 6'd55) state_d = ST_LEN;
			end
			ST_LEN: if (pos_q == 6'd63) state_d = ST_ROUND;
			ST_ROUND: begin
				if (rnd_q == 7'd80) begin
					if (!endp_q) state_d = ST_IDLE;
					else if (cnt_q == 3'd7) state_d = ST_EMIT;
					else state_d = ST_PAD;
				end
			end
			ST_EMIT: if (out_ready && cnt_q == 3'd4) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_pop = (state_q == ST_ABSORB);
		out_valid = (state_q == ST_EMIT);
		out_data.digest_word = h_q[cnt_q];
		out_data.last_word = (cnt_q == 3'd4);
	end

	// round engine: rnd_q counts 0 (load) then 1..80 (round rnd_q-1)
	assign t = rnd_q - 7'd1;
	always_comb begin
		if (t < 7'd16) wt2 = w_q[t[3:0]];
		else begin
			wt2 = w_q[4'(t + 7'd13)] ^ w_q[4'(t + 7'd8)] ^ w_q[4'(t + 7'd2)] ^ w_q[t[3:0]];
			wt2 = {wt2[30:0], wt2[31]};
		end
		if (t < 7'd20) begin
			f2 = (r_q[1] & r_q[2]) | (~r_q[1] & r_q[3]);
			k2 = K0;
		end else if (t < 7'd40) begin
			f2 = r_q[1] ^ r_q[2] ^ r_q[3];
			k2 = K1;
		end else if (t < 7'd60) begin
			f2 = (r_q[1] & r_q[2]) | (r_q[1] & r_q[3]) | (r_q[2] & r_q[3]);
			k2 = K2;
		end else begin
			f2 = r_q[1] ^ r_q[2] ^ r_q[3];
			k2 = K3;
		end
		tmp2 = {r_q[0][26:0], r_q[0][31:27]} + f2 + r_q[4] + k2 + wt2;
	end

	always_ff @(posedge clk) begin
		if (put) begin
			acc_q <= {acc_q[23:0], put_byte};
			if (pos_q[1:0] == 2'd3) w_q[pos_q[5:2]] <= {acc_q[23:0], put_byte};
		end
		if (state_q == ST_ABSORB) len_q <= bits_q + 64'(in_data.byte_present) * 64'd8;
		else if (state_q == ST_LEN) len_q <= {len_q[55:0], 8'h00};
		if (state_q == ST_ROUND) begin
			if (rnd_q == 7'd0) begin
				for (int i = 0; i < 5; i++) r_q[i] <= h_q[i];
			end else begin
				if (t >= 7'd16) w_q[t[3:0]] <= wt2;
				r_q[0] <= tmp2;
				r_q[1] <= r_q[0];
				r_q[2] <= {r_q[1][1:0], r_q[1][31:2]};
				r_q[3] <= r_q[2];
				r_q[4] <= r_q[3];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			h_q[0] <= H0_INIT; h_q[1] <= H1_INIT; h_q[2] <= H2_INIT;
			h_q[3] <= H3_INIT; h_q[4] <= H4_INIT;
			pos_q <= 6'd0;
			bits_q <= 64'd0;
			rnd_q <= 7'd0;
			cnt_q <= 3'd0;
			fin_q <= 1'b0;
			endp_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (put) pos_q <= pos_q + 6'd1;
			case (state_q)
				ST_ABSORB: begin
					if (in_data.byte_present) bits_q <= bits_q + 64'd8;
					endp_q <= in_data.message_end;
					fin_q <= 1'b0;
					rnd_q <= 7'd0;
					cnt_q <= 3'd0;
				end
				ST_PAD: begin
					fin_q <= 1'b1;
					rnd_q <= 7'd0;
					if (pos_q == 6'd55) cnt_q <= 3'd0;
					else if (pos_q == 6'd63) cnt_q <= 3'd1;
				end
				ST_LEN: begin
					rnd_q <= 7'd0;
					cnt_q <= 3'd7;
				end
				ST_ROUND: begin
					rnd_q <= rnd_q + 7'd1;
					if (rnd_q == 7'd80) begin
						h_q[0] <= h_q[0] + tmp2;
						h_q[1] <= h_q[1] + r_q[0];
						h_q[2] <= h_q[2] + {r_q[1][1:0], r_q[1][31:2]};
						h_q[3] <= h_q[3] + r_q[2];
						h_q[4] <= h_q[4] + r_q[3];
						if (cnt_q == 3'd7) cnt_q <= 3'd0;
					end
				end
				ST_EMIT: begin
					if (out_ready) begin
						cnt_q <= cnt_q + 3'd1;
						if (cnt_q == 3'd4) begin
							h_q[0] <= H0_INIT; h_q[1] <= H1_INIT; h_q[2] <= H2_INIT;
							h_q[3] <= H3_INIT; h_q[4] <= H4_INIT;
							bits_q <= 64'd0;
							pos_q <= 6'd0;
						end
					end
				end
				default: ;
			endcase
		end
	end
endmodule

[rtl/sha1_message_digest_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// SHA-1 message digest unit
// Streams message bytes in, returns the five digest words per message.
// ----------------------------------------------------------------------------
// Input channel: one word per message byte {data_byte, byte_present,
// message_end}; an idle word (no byte, no end) changes nothing.
// Output channel: five words H0..H4 per message, last_word on H4.
// A two-entry queue decouples input acceptance from the core.
// Each word passes through the core's IDLE and ABSORB states; every 64th byte
// adds a run of the round engine, one SHA-1 round per cycle.
// At message end, padding and length feed one byte per cycle (up to 72
// bytes over two blocks), each filled block is compressed by the round engine,
// then the digest is emitted, one word per cycle while the receiver is ready.
// Reset restores the initial hash constants and clears length and position.
// A stalled receiver holds the current digest word; the queue keeps
// accepting until full.
// ----------------------------------------------------------------------------
module sha1_message_digest_unit (
	input  logic clk,
	input  logic arst_n,
	sha1_if.sink   in_ch,
	sha1_if.source out_ch
);
	import sha1_pkg::*;
	in_word_t  q_data;
	out_word_t o_data;
	logic full, empty, pop, o_valid;

	assign in_ch.ready = !full;

	sha1_fifo u_fifo (
		.clk(clk), .arst_n(arst_n),
		.push(in_ch.valid), .push_data(in_word_t'(in_ch.data)), .full(full),
		.pop(pop), .pop_data(q_data), .empty(empty)
	);

	sha1_core u_core (
		.clk(clk), .arst_n(arst_n),
		.in_valid(!empty), .in_data(q_data), .in_pop(pop),
		.out_valid(o_valid), .out_data(o_data), .out_ready(out_ch.ready)
	);

	assign out_ch.valid = o_valid;
	assign out_ch.data = o_data;

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		o_valid && !out_ch.ready |=> o_valid && $stable(o_data))
		else $error("digest word changed under stall");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("pop from empty queue");
endmodule
